/* hw/rtl/tlc_pkg.sv */
// tlc_pkg: types and constants shared by the two-way traffic light controller
// lamp and mode codes, transaction payload structs, configuration register set
// no dependencies
package tlc_pkg;

  localparam int unsigned SEC_W      = 7;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned TIMER_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_SECONDS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBER_SECONDS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SECONDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS      = 3'd4;

  localparam logic [SEC_W-1:0]  RED_SECONDS_RST      = 7'd5;
  localparam logic [SEC_W-1:0]  AMBER_SECONDS_RST    = 7'd2;
  localparam logic [SEC_W-1:0]  GREEN_SECONDS_RST    = 7'd3;
  localparam logic [TICK_W-1:0] TICKS_PER_SECOND_RST = 10'd100;
  localparam logic [TICK_W-1:0] BLINK_TICKS_RST      = 10'd25;

  typedef enum logic [1:0] {
    LAMP_OFF   = 2'd0,
    LAMP_RED   = 2'd1,
    LAMP_AMBER = 2'd2,
    LAMP_GREEN = 2'd3
  } lamp_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RED    = 2'd1,
    MODE_AMBER  = 2'd2,
    MODE_GREEN  = 2'd3
  } mode_t;

  typedef struct packed {
    logic tick;
    logic mode_press;
  } tlc_in_t;

  typedef struct packed {
    logic [1:0]       light_a;
    logic [1:0]       light_b;
    logic [SEC_W-1:0] display_a;
    logic [SEC_W-1:0] display_b;
  } tlc_out_t;

  typedef struct packed {
    logic [SEC_W-1:0]  red_seconds;
    logic [SEC_W-1:0]  amber_seconds;
    logic [SEC_W-1:0]  green_seconds;
    logic [TICK_W-1:0] ticks_per_second;
    logic [TICK_W-1:0] blink_ticks;
  } tlc_cfg_t;

endpackage

/* hw/rtl/two_way_traffic_light_controller.sv */
// two_way_traffic_light_controller: two-direction lamp sequencer with modify modes
// path: an accepted item is held in the input register, then the updated state lands
// in the result register, which raises result_valid
// throughput: one item per cycle while result_ready stays high; the state update is a single pass of counter logic
// reset: synchronous rst restores register defaults, normal mode, A red and B green
// depends on tlc_pkg, tlc_cfg, tlc_in_stage, tlc_ctrl, tlc_out_stage
module two_way_traffic_light_controller
  import tlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tlc_in_t               item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output tlc_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tlc_cfg_t cfg;
  logic     held_valid;
  logic     held_take;
  tlc_in_t  held_item;
  tlc_out_t step_result;

  tlc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_item  (held_item)
  );

  tlc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (held_valid && held_take),
    .step_item   (held_item),
    .step_result (step_result)
  );

  tlc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (held_valid),
    .load_ready   (held_take),
    .load_data    (step_result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* hw/rtl/tlc_cfg.sv */
// tlc_cfg: configuration register file with write-only port
// depends on tlc_pkg
module tlc_cfg
  import tlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output tlc_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_seconds      <= RED_SECONDS_RST;
      cfg.amber_seconds    <= AMBER_SECONDS_RST;
      cfg.green_seconds    <= GREEN_SECONDS_RST;
      cfg.ticks_per_second <= TICKS_PER_SECOND_RST;
      cfg.blink_ticks      <= BLINK_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RED_SECONDS:      cfg.red_seconds      <= cfg_data[SEC_W-1:0];
        CFG_AMBER_SECONDS:    cfg.amber_seconds    <= cfg_data[SEC_W-1:0];
        CFG_GREEN_SECONDS:    cfg.green_seconds    <= cfg_data[SEC_W-1:0];
        CFG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data[TICK_W-1:0];
        CFG_BLINK_TICKS:      cfg.blink_ticks      <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/tlc_in_stage.sv */
// tlc_in_stage: input register for one item transaction
// depends on tlc_pkg
module tlc_in_stage
  import tlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  tlc_in_t item,
  output logic    held_valid,
  input  logic    held_take,
  output tlc_in_t held_item
);

  assign item_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

endmodule

/* hw/rtl/tlc_ctrl.sv */
// tlc_ctrl: controller state (mode, lamps, countdowns, timers) and its update
// depends on tlc_pkg; advances one step per strobe and presents the new outputs
module tlc_ctrl
  import tlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tlc_cfg_t cfg,
  input  logic     step,
  input  tlc_in_t  step_item,
  output tlc_out_t step_result
);

  mode_t              mode, mode_next;
  lamp_t              lamp_a, lamp_a_next;
  lamp_t              lamp_b, lamp_b_next;
  logic [SEC_W-1:0]   count_a, count_a_next;
  logic [SEC_W-1:0]   count_b, count_b_next;
  logic [TIMER_W-1:0] second_timer, second_timer_next;
  logic [TIMER_W-1:0] phase_timer_a, phase_timer_a_next;
  logic [TIMER_W-1:0] phase_timer_b, phase_timer_b_next;

  logic [TIMER_W-1:0] load_red, load_amber, load_green;
  logic [TIMER_W-1:0] load_tps, load_blink;
  logic               fire_s, fire_a, fire_b;
  mode_t              mode_up;

  assign load_red   = TIMER_W'(cfg.red_seconds * cfg.ticks_per_second);
  assign load_amber = TIMER_W'(cfg.amber_seconds * cfg.ticks_per_second);
  assign load_green = TIMER_W'(cfg.green_seconds * cfg.ticks_per_second);
  assign load_tps   = TIMER_W'(cfg.ticks_per_second);
  assign load_blink = TIMER_W'(cfg.blink_ticks);
  assign mode_up    = mode_t'(mode + 2'd1);

  always_comb begin
    mode_next          = mode;
    lamp_a_next        = lamp_a;
    lamp_b_next        = lamp_b;
    count_a_next       = count_a;
    count_b_next       = count_b;
    second_timer_next  = second_timer;
    phase_timer_a_next = phase_timer_a;
    phase_timer_b_next = phase_timer_b;
    fire_s             = 1'b0;
    fire_a             = 1'b0;
    fire_b             = 1'b0;

    if (step_item.tick) begin
      if (second_timer != '0) begin
        second_timer_next = second_timer - TIMER_W'(1);
        fire_s            = (second_timer == TIMER_W'(1));
      end
      if (phase_timer_a != '0) begin
        phase_timer_a_next = phase_timer_a - TIMER_W'(1);
        fire_a             = (phase_timer_a == TIMER_W'(1));
      end
      if (phase_timer_b != '0) begin
        phase_timer_b_next = phase_timer_b - TIMER_W'(1);
        fire_b             = (phase_timer_b == TIMER_W'(1));
      end
    end

    if (mode == MODE_NORMAL) begin
      if (fire_s) begin
        second_timer_next = load_tps;
        if (count_a_next != '0) count_a_next = count_a_next - SEC_W'(1);
        if (count_b_next != '0) count_b_next = count_b_next - SEC_W'(1);
      end
      if (fire_a) begin
        unique case (lamp_a)
          LAMP_RED: begin
            lamp_a_next = LAMP_GREEN; count_a_next = cfg.green_seconds;
            phase_timer_a_next = load_green;
          end
          LAMP_AMBER: begin
            lamp_a_next = LAMP_RED; count_a_next = cfg.red_seconds;
            phase_timer_a_next = load_red;
          end
          LAMP_GREEN: begin
            lamp_a_next = LAMP_AMBER; count_a_next = cfg.amber_seconds;
            phase_timer_a_next = load_amber;
          end
          default: ;
        endcase
      end
      if (fire_b) begin
        unique case (lamp_b)
          LAMP_RED: begin
            lamp_b_next = LAMP_GREEN; count_b_next = cfg.green_seconds;
            phase_timer_b_next = load_green;
          end
          LAMP_AMBER: begin
            lamp_b_next = LAMP_RED; count_b_next = cfg.red_seconds;
            phase_timer_b_next = load_red;
          end
          LAMP_GREEN: begin
            lamp_b_next = LAMP_AMBER; count_b_next = cfg.amber_seconds;
            phase_timer_b_next = load_amber;
          end
          default: ;
        endcase
      end
      if (step_item.mode_press) begin
        mode_next         = MODE_RED;
        second_timer_next = load_blink;
        count_a_next      = SEC_W'(MODE_RED) + SEC_W'(1);
        count_b_next      = cfg.red_seconds;
        lamp_a_next       = LAMP_OFF;
        lamp_b_next       = LAMP_OFF;
      end
    end else begin
      // blink between off and the colour being modified
      if (fire_s) begin
        if (lamp_a == LAMP_OFF) begin
          second_timer_next = load_blink;
          lamp_a_next       = lamp_t'(mode);
          lamp_b_next       = lamp_t'(mode);
        end else if (lamp_a == lamp_t'(mode)) begin
          second_timer_next = load_blink;
          lamp_a_next       = LAMP_OFF;
          lamp_b_next       = LAMP_OFF;
        end
      end
      if (step_item.mode_press) begin
        mode_next = mode_up;
        if (mode_up == MODE_NORMAL) begin
          second_timer_next  = load_tps;
          phase_timer_a_next = load_red;
          phase_timer_b_next = load_green;
          count_a_next       = cfg.red_seconds;
          count_b_next       = cfg.green_seconds;
          lamp_a_next        = LAMP_RED;
          lamp_b_next        = LAMP_GREEN;
        end else begin
          second_timer_next = load_blink;
          count_a_next      = SEC_W'(mode_up) + SEC_W'(1);
          count_b_next      = (mode_up == MODE_AMBER) ? cfg.amber_seconds
                                                      : cfg.green_seconds;
          lamp_a_next       = LAMP_OFF;
          lamp_b_next       = LAMP_OFF;
        end
      end
    end

    step_result.light_a   = lamp_a_next;
    step_result.light_b   = lamp_b_next;
    step_result.display_a = count_a_next;
    step_result.display_b = count_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      lamp_a        <= LAMP_RED;
      lamp_b        <= LAMP_GREEN;
      count_a       <= RED_SECONDS_RST;
      count_b       <= GREEN_SECONDS_RST;
      second_timer  <= TIMER_W'(TICKS_PER_SECOND_RST);
      phase_timer_a <= TIMER_W'(RED_SECONDS_RST * TICKS_PER_SECOND_RST);
      phase_timer_b <= TIMER_W'(GREEN_SECONDS_RST * TICKS_PER_SECOND_RST);
    end else if (step) begin
      mode          <= mode_next;
      lamp_a        <= lamp_a_next;
      lamp_b        <= lamp_b_next;
      count_a       <= count_a_next;
      count_b       <= count_b_next;
      second_timer  <= second_timer_next;
      phase_timer_a <= phase_timer_a_next;
      phase_timer_b <= phase_timer_b_next;
    end
  end

endmodule

/* hw/rtl/tlc_out_stage.sv */
// tlc_out_stage: result register holding one transaction until taken
// depends on tlc_pkg
module tlc_out_stage
  import tlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load_valid,
  output logic     load_ready,
  input  tlc_out_t load_data,
  output logic     result_valid,
  input  logic     result_ready,
  output tlc_out_t result
);

  assign load_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      result <= load_data;
    end
  end

endmodule

/* test/tb_two_way_traffic_light_controller.sv */
// tb_two_way_traffic_light_controller: self-checking bench for the two-way traffic light controller
// walks a directed plan, then random phases under new register settings, with a built-in predictor
// depends on tlc_pkg and two_way_traffic_light_controller
module tb_two_way_traffic_light_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import tlc_pkg::*;

  localparam int unsigned RAND_ITEMS    = 500;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_BLINK_TICKS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_TYPED,
    STEP_CFG
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    tlc_in_t               stim;
    tlc_out_t              want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_step_t;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  tlc_in_t               item;
  logic                  result_valid;
  logic                  result_ready;
  tlc_out_t              result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  two_way_traffic_light_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor copy of registers and state
  logic [SEC_W-1:0]   red_s, amber_s, green_s;
  logic [TICK_W-1:0]  tps, blink;
  mode_t              cur_mode;
  lamp_t              lamp_a, lamp_b;
  logic [SEC_W-1:0]   count_a, count_b;
  logic [TIMER_W-1:0] sec_left, phase_a_left, phase_b_left;

  tlc_out_t    pending_lights[$];
  plan_step_t  plan[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned ready_hold;
  tlc_out_t    want;

  always #1 clk = ~clk;

  function automatic logic [TIMER_W-1:0] phase_ticks(logic [SEC_W-1:0] secs);
    logic [TIMER_W-1:0] prod;
    prod = TIMER_W'(secs) * TIMER_W'(tps);
    return prod;
  endfunction

  function automatic logic [SEC_W-1:0] lamp_secs(lamp_t l);
    case (l)
      LAMP_RED:   return red_s;
      LAMP_AMBER: return amber_s;
      LAMP_GREEN: return green_s;
      default:    return '0;
    endcase
  endfunction

  function automatic lamp_t next_lamp(lamp_t l);
    case (l)
      LAMP_RED:   return LAMP_GREEN;
      LAMP_AMBER: return LAMP_RED;
      LAMP_GREEN: return LAMP_AMBER;
      default:    return l;
    endcase
  endfunction

  function automatic void enter_mode(mode_t m);
    cur_mode = m;
    if (m == MODE_NORMAL) begin
      sec_left     = TIMER_W'(tps);
      phase_a_left = phase_ticks(red_s);
      phase_b_left = phase_ticks(green_s);
      count_a      = red_s;
      count_b      = green_s;
      lamp_a       = LAMP_RED;
      lamp_b       = LAMP_GREEN;
    end else begin
      sec_left = TIMER_W'(blink);
      count_a  = SEC_W'(m) + SEC_W'(1);
      count_b  = lamp_secs(lamp_t'(m));
      lamp_a   = LAMP_OFF;
      lamp_b   = LAMP_OFF;
    end
  endfunction

  function automatic void reset_predictor();
    red_s   = RED_SECONDS_RST;
    amber_s = AMBER_SECONDS_RST;
    green_s = GREEN_SECONDS_RST;
    tps     = TICKS_PER_SECOND_RST;
    blink   = BLINK_TICKS_RST;
    enter_mode(MODE_NORMAL);
  endfunction

  function automatic tlc_out_t predict_lights(tlc_in_t it);
    logic       fire_s, fire_a, fire_b;
    logic [1:0] step_mode;
    lamp_t      colour;
    tlc_out_t   res;
    fire_s = it.tick && sec_left == 1;
    fire_a = it.tick && phase_a_left == 1;
    fire_b = it.tick && phase_b_left == 1;
    if (it.tick) begin
      if (sec_left != 0) sec_left = sec_left - TIMER_W'(1);
      if (phase_a_left != 0) phase_a_left = phase_a_left - TIMER_W'(1);
      if (phase_b_left != 0) phase_b_left = phase_b_left - TIMER_W'(1);
    end
    colour = lamp_t'(cur_mode);
    if (cur_mode == MODE_NORMAL) begin
      if (fire_s) begin
        sec_left = TIMER_W'(tps);
        if (count_a != 0) count_a = count_a - SEC_W'(1);
        if (count_b != 0) count_b = count_b - SEC_W'(1);
      end
      if (fire_a && lamp_a != LAMP_OFF) begin
        lamp_a       = next_lamp(lamp_a);
        count_a      = lamp_secs(lamp_a);
        phase_a_left = phase_ticks(count_a);
      end
      if (fire_b && lamp_b != LAMP_OFF) begin
        lamp_b       = next_lamp(lamp_b);
        count_b      = lamp_secs(lamp_b);
        phase_b_left = phase_ticks(count_b);
      end
      if (it.mode_press) enter_mode(MODE_RED);
    end else begin
      if (fire_s) begin
        if (lamp_a == LAMP_OFF) begin
          sec_left = TIMER_W'(blink);
          lamp_a   = colour;
          lamp_b   = colour;
        end else if (lamp_a == colour) begin
          sec_left = TIMER_W'(blink);
          lamp_a   = LAMP_OFF;
          lamp_b   = LAMP_OFF;
        end
      end
      if (it.mode_press) begin
        step_mode = cur_mode + 2'd1;
        enter_mode(mode_t'(step_mode));
      end
    end
    res.light_a   = lamp_a;
    res.light_b   = lamp_b;
    res.display_a = count_a;
    res.display_b = count_b;
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SEC_W-1:0] pick_seconds();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 90) return SEC_W'($urandom_range(1, 4));
    return SEC_W'($urandom_range(5, 99));
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 90) return TICK_W'($urandom_range(1, 3));
    return TICK_W'($urandom_range(4, 1000));
  endfunction

  function automatic void add_item(logic t, logic p);
    plan_step_t s;
    s = '0;
    s.kind            = STEP_ITEM;
    s.stim.tick       = t;
    s.stim.mode_press = p;
    plan.push_back(s);
  endfunction

  function automatic void add_typed(logic t, logic p, lamp_t la, lamp_t lb,
                                    logic [SEC_W-1:0] da, logic [SEC_W-1:0] db);
    plan_step_t s;
    s = '0;
    s.kind            = STEP_TYPED;
    s.stim.tick       = t;
    s.stim.mode_press = p;
    s.want.light_a    = la;
    s.want.light_b    = lb;
    s.want.display_a  = da;
    s.want.display_b  = db;
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    plan.push_back(s);
  endfunction

  function automatic void check_field(string name, logic [SEC_W-1:0] want_v,
                                      logic [SEC_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  task automatic send_item(tlc_in_t stim, logic typed, tlc_out_t typed_want);
    tlc_out_t predicted;
    item_valid <= 1'b1;
    item       <= stim;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = predict_lights(stim);
    pending_lights.push_back(typed ? typed_want : predicted);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n != 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RED_SECONDS:      red_s   = data[SEC_W-1:0];
      CFG_AMBER_SECONDS:    amber_s = data[SEC_W-1:0];
      CFG_GREEN_SECONDS:    green_s = data[SEC_W-1:0];
      CFG_TICKS_PER_SECOND: tps     = data;
      CFG_BLINK_TICKS:      blink   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (result_ready) begin
      result_ready <= 1'b0;
      ready_hold   <= gap_len();
    end else begin
      result_ready <= 1'b1;
      ready_hold   <= ($urandom_range(0, 99) < 10) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_lights.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction %h", $time, result);
      end else begin
        want = pending_lights.pop_front();
        check_field("light_a", SEC_W'(want.light_a), SEC_W'(result.light_a));
        check_field("light_b", SEC_W'(want.light_b), SEC_W'(result.light_b));
        check_field("display_a", want.display_a, result.display_a);
        check_field("display_b", want.display_b, result.display_b);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tlc_in_t           stim;
    logic [SEC_W-1:0]  set_red, set_amber, set_green;
    logic [TICK_W-1:0] set_tps, set_blink;
    int unsigned       random_sent;
    int unsigned       phase;
    int unsigned       burst;
    logic              steady;

    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    cycles       = 0;
    ready_hold   = 0;
    random_sent  = 0;
    phase        = 0;
    reset_predictor();

    // after reset, out-of-range writes, walk of all modes
    add_typed(1'b0, 1'b0, LAMP_RED, LAMP_GREEN, 7'd5, 7'd3);
    add_item(1'b1, 1'b0);
    add_cfg(CFG_UNUSED_FIRST, 10'd1);
    add_cfg(CFG_UNUSED_LAST, '1);
    add_typed(1'b0, 1'b1, LAMP_OFF, LAMP_OFF, 7'd2, 7'd5);
    // new red length shows only at the next reload
    add_cfg(CFG_RED_SECONDS, 10'd9);
    add_typed(1'b0, 1'b1, LAMP_OFF, LAMP_OFF, 7'd3, 7'd2);
    add_typed(1'b0, 1'b1, LAMP_OFF, LAMP_OFF, 7'd4, 7'd3);
    add_typed(1'b0, 1'b1, LAMP_RED, LAMP_GREEN, 7'd9, 7'd3);
    // fast timers, zero amber holds its lamp, countdowns sit at zero
    add_cfg(CFG_RED_SECONDS, 10'd1);
    add_cfg(CFG_AMBER_SECONDS, 10'd0);
    add_cfg(CFG_GREEN_SECONDS, 10'd1);
    add_cfg(CFG_TICKS_PER_SECOND, 10'd1);
    add_cfg(CFG_BLINK_TICKS, 10'd1);
    add_item(1'b1, 1'b1);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b1);
    add_typed(1'b0, 1'b1, LAMP_RED, LAMP_GREEN, 7'd1, 7'd1);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b0);
    // zero blink never toggles
    add_cfg(CFG_BLINK_TICKS, 10'd0);
    add_item(1'b0, 1'b1);
    add_item(1'b1, 1'b0);
    // largest settings
    add_cfg(CFG_RED_SECONDS, 10'd99);
    add_cfg(CFG_AMBER_SECONDS, 10'd99);
    add_cfg(CFG_GREEN_SECONDS, 10'd99);
    add_cfg(CFG_TICKS_PER_SECOND, 10'd1000);
    add_cfg(CFG_BLINK_TICKS, 10'd1000);
    add_typed(1'b0, 1'b1, LAMP_OFF, LAMP_OFF, 7'd3, 7'd99);
    add_typed(1'b0, 1'b1, LAMP_OFF, LAMP_OFF, 7'd4, 7'd99);
    add_typed(1'b0, 1'b1, LAMP_RED, LAMP_GREEN, 7'd99, 7'd99);
    add_item(1'b1, 1'b1);
    add_item(1'b1, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].stim, plan[i].kind == STEP_TYPED, plan[i].want);
        idle_gap(gap_len());
      end
    end

    while (random_sent < RAND_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        set_red   = 7'd1;
        set_amber = 7'd1;
        set_green = 7'd1;
        set_tps   = 10'd1;
        set_blink = 10'd1;
      end else if (phase == 1) begin
        set_red   = 7'd99;
        set_amber = 7'd99;
        set_green = 7'd99;
        set_tps   = 10'd1000;
        set_blink = 10'd1000;
      end else begin
        set_red   = pick_seconds();
        set_amber = pick_seconds();
        set_green = pick_seconds();
        set_tps   = pick_ticks();
        set_blink = pick_ticks();
      end
      write_reg(CFG_RED_SECONDS, CFG_DATA_W'(set_red));
      write_reg(CFG_AMBER_SECONDS, CFG_DATA_W'(set_amber));
      write_reg(CFG_GREEN_SECONDS, CFG_DATA_W'(set_green));
      write_reg(CFG_TICKS_PER_SECOND, set_tps);
      write_reg(CFG_BLINK_TICKS, set_blink);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                  CFG_DATA_W'($urandom));
      burst = (phase == 1) ? 30 : $urandom_range(30, 70);
      repeat (burst) begin
        stim.tick       = ($urandom_range(0, 99) < 85);
        stim.mode_press = ($urandom_range(0, 99) < 6);
        send_item(stim, 1'b0, '0);
        random_sent++;
        if (!steady) idle_gap(gap_len());
      end
      phase++;
    end

    drain();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
